// ===== hdl/triangle_pixel_depth_test_top_defines.svh =====
// assertion macros shared by the triangle depth test rtl
// expects clk and rst to be visible in the module that uses them
`ifndef TRIANGLE_PIXEL_DEPTH_TEST_TOP_DEFINES_SVH
`define TRIANGLE_PIXEL_DEPTH_TEST_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TPDT_ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// next-cycle implication, off during reset
`define TPDT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hdl/tpdt_pkg.sv =====
// shared types and constants for the triangle depth test block
// no dependencies
`default_nettype none

package tpdt_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int IDX_W          = 18;
  localparam int Q_DEPTH        = 4;
  localparam int Q_PW           = $clog2(Q_DEPTH);
  localparam int DIV_STEPS      = 17;

  localparam logic [15:0] FAR_DEPTH = 16'hFFFF;
  localparam logic [8:0]  DIM_RESET = 9'd256;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TEST  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [2:0] STAT_WRITTEN    = 3'd0;
  localparam logic [2:0] STAT_CULLED     = 3'd1;
  localparam logic [2:0] STAT_OUTSIDE    = 3'd2;
  localparam logic [2:0] STAT_DEPTH_FAIL = 3'd3;
  localparam logic [2:0] STAT_LOADED     = 3'd4;
  localparam logic [2:0] STAT_CLEARED    = 3'd5;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_TEST,
    KIND_CLEAR,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        slot;
    logic [15:0]       vx;
    logic [15:0]       vy;
    logic [15:0]       vz;
    logic [15:0]       vw;
    logic              on;
    logic [IDX_W-1:0]  idx;
    logic [11:0]       cx;
    logic [11:0]       cy;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_SUM,
    S_CHK,
    S_TMUL,
    S_TSUM,
    S_SHIFT,
    S_ZMUL,
    S_ZADD,
    S_ZSUM,
    S_DIVGO,
    S_DIVWAIT,
    S_CMP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/tpdt_front.sv =====
// front end: screen size registers, request classification, buffer index
// depends on tpdt_pkg
`default_nettype none

module tpdt_front
  import tpdt_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [1:0]         vertex_slot,
  input  logic signed [15:0] vert_x,
  input  logic signed [15:0] vert_y,
  input  logic [15:0]        vert_z,
  input  logic [15:0]        vert_w,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  input  logic               q_full,
  input  logic               clearing,
  output logic               push,
  output entry_t             entry
);

  logic [8:0]       screen_width;
  logic [8:0]       screen_height;
  logic [8:0]       w_eff;
  logic [8:0]       h_eff;
  logic             on;
  logic [8:0]       row;
  logic [IDX_W-1:0] idx;
  kind_t            kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_RESET;
      screen_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (screen_width == 9'd0)
      w_eff = 9'd1;
    else if (32'(screen_width) > MAX_WIDTH)
      w_eff = 9'(MAX_WIDTH);
    else
      w_eff = screen_width;
    if (screen_height == 9'd0)
      h_eff = 9'd1;
    else if (32'(screen_height) > MAX_HEIGHT)
      h_eff = 9'(MAX_HEIGHT);
    else
      h_eff = screen_height;
  end

  assign on  = ({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff);
  assign row = h_eff - 9'd1 - {1'b0, pixel_y};
  assign idx = on ? (({9'b0, row} * {9'b0, w_eff}) + {10'b0, pixel_x}) : '0;

  always_comb begin
    case (mode)
      MODE_LOAD:  kind = (vertex_slot == SLOT_A || vertex_slot == SLOT_B ||
                          vertex_slot == SLOT_C) ? KIND_LOAD : KIND_REJECT;
      MODE_TEST:  kind = KIND_TEST;
      MODE_CLEAR: kind = on ? KIND_CLEAR : KIND_REJECT;
      default:    kind = KIND_REJECT;
    endcase
  end

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    entry.kind = kind;
    entry.slot = vertex_slot;
    entry.vx   = vert_x;
    entry.vy   = vert_y;
    entry.vz   = vert_z;
    entry.vw   = vert_w;
    entry.on   = on;
    entry.idx  = idx;
    entry.cx   = {pixel_x, 4'b1000};
    entry.cy   = {pixel_y, 4'b1000};
  end

endmodule

`default_nettype wire

// ===== hdl/tpdt_fifo.sv =====
// short request queue between front end and back end
// depends on tpdt_pkg and the assertion macro header
`default_nettype none
`include "triangle_pixel_depth_test_top_defines.svh"

module tpdt_fifo
  import tpdt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t rdata
);

  entry_t          slots [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_PW:0]   count;

  assign full  = (count == (Q_PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == Q_PW'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == Q_PW'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TPDT_ASSERT_IMPLIES(a_push_not_full, push, !full, "request pushed into full queue")
  `TPDT_ASSERT_IMPLIES(a_pop_not_empty, pop, !empty, "request popped from empty queue")
  `TPDT_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== hdl/tpdt_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on tpdt_pkg
`default_nettype none

module tpdt_div
  import tpdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [16:0] quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [47:0] rem;
  logic [16:0] nlow;
  logic [47:0] trial;
  logic        take;

  assign trial = {rem[46:0], nlow[16]};
  assign take  = (trial >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num[63:17]};
      nlow <= num[16:0];
    end else if (busy) begin
      rem  <= take ? (trial - den) : trial;
      nlow <= {nlow[15:0], 1'b0};
      quo  <= {quo[15:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tpdt_back.sv =====
// back end: vertex store, edge and weight datapath, depth store, result register
// depends on tpdt_pkg, tpdt_div and the assertion macro header
`default_nettype none
`include "triangle_pixel_depth_test_top_defines.svh"

module tpdt_back
  import tpdt_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] frame_index,
  output logic [15:0] frag_depth,
  output logic [16:0] weight_a,
  output logic [16:0] weight_b,
  output logic [16:0] weight_c
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW > IDX_W) ? AW : IDX_W;

  state_t state;
  state_t state_next;
  entry_t cur;

  logic signed [15:0] vtx_x [3];
  logic signed [15:0] vtx_y [3];
  logic [15:0]        vtx_z [3];
  logic [15:0]        vtx_w [3];
  logic [15:0]        weff  [3];

  logic signed [16:0] diff  [14];
  logic signed [33:0] prod  [8];
  logic [31:0]        wprod [3];
  logic signed [34:0] d_val;
  logic signed [34:0] n_val [3];
  logic [30:0]        u_val [3];
  logic [30:0]        u_next [3];
  logic [62:0]        t_val [3];
  logic [63:0]        t_sum;
  logic [46:0]        tn    [3];
  logic [47:0]        t_tot;
  logic [39:0]        zlo   [3];
  logic [38:0]        zhi   [3];
  logic [62:0]        zp    [3];
  logic [63:0]        dnum;
  logic [16:0]        wq    [3];
  logic [16:0]        dep_q;
  logic [1:0]         div_sel;
  logic [1:0]         s1;
  logic [4:0]         s2;
  logic signed [16:0] px_s;
  logic signed [16:0] py_s;
  logic               chk_pass;
  logic [15:0]        dep_c;
  logic               fail;

  logic [2:0]  res_status;
  logic [15:0] res_idx;
  logic [15:0] res_dep;
  logic [16:0] res_w [3];

  logic [AW-1:0] clr_addr;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] cur_addr;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  logic        div_start;
  logic        div_done;
  logic [16:0] div_quo;
  logic [63:0] div_num;
  logic        emit_ok;

  tpdt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (t_tot),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign idx_ext  = IW'(cur.idx);
  assign cur_addr = idx_ext[AW-1:0];
  assign px_s     = $signed({5'b0, cur.cx});
  assign py_s     = $signed({5'b0, cur.cy});

  always_comb begin
    for (int k = 0; k < 3; k++)
      weff[k] = (vtx_w[k] == 16'd0) ? 16'd1 : vtx_w[k];
  end

  always_comb begin
    if (d_val[33])      s1 = 2'd3;
    else if (d_val[32]) s1 = 2'd2;
    else if (d_val[31]) s1 = 2'd1;
    else                s1 = 2'd0;
    for (int k = 0; k < 3; k++)
      u_next[k] = 31'($unsigned(n_val[k]) >> s1);
  end

  always_comb begin
    s2 = 5'd0;
    for (int k = 0; k < 16; k++)
      if (t_sum[47+k]) s2 = 5'(k + 1);
  end

  assign chk_pass = !(d_val[34] || d_val == '0) && cur.on &&
                    !n_val[0][34] && !n_val[1][34] && !n_val[2][34];

  always_comb begin
    case (div_sel)
      2'd0:    div_num = {1'b0, tn[0], 16'b0} + 64'(t_tot >> 1);
      2'd1:    div_num = {1'b0, tn[1], 16'b0} + 64'(t_tot >> 1);
      2'd2:    div_num = {1'b0, tn[2], 16'b0} + 64'(t_tot >> 1);
      default: div_num = dnum;
    endcase
  end

  assign dep_c = (dep_q[16]) ? FAR_DEPTH : dep_q[15:0];
  assign fail  = (dep_c > rd_data);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr_addr == AW'(DEPTH-1)) state_next = S_IDLE;
      S_IDLE:    if (!q_empty) state_next = S_EXEC;
      S_EXEC:    state_next = (cur.kind == KIND_TEST) ? S_MUL : S_EMIT;
      S_MUL:     state_next = S_SUM;
      S_SUM:     state_next = S_CHK;
      S_CHK:     state_next = chk_pass ? S_TMUL : S_EMIT;
      S_TMUL:    state_next = S_TSUM;
      S_TSUM:    state_next = S_SHIFT;
      S_SHIFT:   state_next = S_ZMUL;
      S_ZMUL:    state_next = S_ZADD;
      S_ZADD:    state_next = S_ZSUM;
      S_ZSUM:    state_next = S_DIVGO;
      S_DIVGO:   state_next = S_DIVWAIT;
      S_DIVWAIT: if (div_done) state_next = (div_sel == 2'd3) ? S_CMP : S_DIVGO;
      S_CMP:     state_next = S_EMIT;
      S_EMIT:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    div_start = 1'b0;
    emit_ok   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = FAR_DEPTH;
    case (state)
      S_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE:  q_pop = !q_empty;
      S_EXEC:  mem_we = (cur.kind == KIND_CLEAR);
      S_DIVGO: div_start = 1'b1;
      S_CMP: begin
        mem_we    = !fail;
        mem_wdata = dep_c;
      end
      S_EMIT:  emit_ok = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_sel   <= 2'd0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        vtx_x[k] <= '0;
        vtx_y[k] <= '0;
        vtx_z[k] <= '0;
        vtx_w[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_ZSUM) div_sel <= 2'd0;
      if (state == S_DIVWAIT && div_done && div_sel != 2'd3) div_sel <= div_sel + 2'd1;
      if (state == S_EXEC && cur.kind == KIND_LOAD) begin
        vtx_x[cur.slot] <= $signed(cur.vx);
        vtx_y[cur.slot] <= $signed(cur.vy);
        vtx_z[cur.slot] <= cur.vz;
        vtx_w[cur.slot] <= cur.vw;
      end
      if (emit_ok) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
    case (state)
      S_EXEC: begin
        diff[0]  <= 17'(vtx_y[2]) - 17'(vtx_y[0]);
        diff[1]  <= 17'(vtx_x[1]) - 17'(vtx_x[0]);
        diff[2]  <= 17'(vtx_x[2]) - 17'(vtx_x[0]);
        diff[3]  <= 17'(vtx_y[1]) - 17'(vtx_y[0]);
        diff[4]  <= py_s - 17'(vtx_y[0]);
        diff[5]  <= px_s - 17'(vtx_x[0]);
        diff[6]  <= py_s - 17'(vtx_y[1]);
        diff[7]  <= 17'(vtx_x[2]) - 17'(vtx_x[1]);
        diff[8]  <= 17'(vtx_y[2]) - 17'(vtx_y[1]);
        diff[9]  <= px_s - 17'(vtx_x[1]);
        diff[10] <= py_s - 17'(vtx_y[2]);
        diff[11] <= 17'(vtx_x[0]) - 17'(vtx_x[2]);
        diff[12] <= 17'(vtx_y[0]) - 17'(vtx_y[2]);
        diff[13] <= px_s - 17'(vtx_x[2]);
        res_idx    <= '0;
        res_dep    <= '0;
        res_w[0]   <= '0;
        res_w[1]   <= '0;
        res_w[2]   <= '0;
        case (cur.kind)
          KIND_LOAD:  res_status <= STAT_LOADED;
          KIND_CLEAR: begin
            res_status <= STAT_CLEARED;
            res_idx    <= cur.idx[15:0];
          end
          default:    res_status <= STAT_OUTSIDE;
        endcase
      end
      S_MUL: begin
        prod[0]  <= 34'(diff[0])  * 34'(diff[1]);
        prod[1]  <= 34'(diff[2])  * 34'(diff[3]);
        prod[2]  <= 34'(diff[4])  * 34'(diff[1]);
        prod[3]  <= 34'(diff[3])  * 34'(diff[5]);
        prod[4]  <= 34'(diff[6])  * 34'(diff[7]);
        prod[5]  <= 34'(diff[8])  * 34'(diff[9]);
        prod[6]  <= 34'(diff[10]) * 34'(diff[11]);
        prod[7]  <= 34'(diff[12]) * 34'(diff[13]);
        wprod[0] <= {16'b0, weff[1]} * {16'b0, weff[2]};
        wprod[1] <= {16'b0, weff[0]} * {16'b0, weff[2]};
        wprod[2] <= {16'b0, weff[0]} * {16'b0, weff[1]};
      end
      S_SUM: begin
        d_val    <= 35'(prod[0]) - 35'(prod[1]);
        n_val[2] <= 35'(prod[2]) - 35'(prod[3]);
        n_val[0] <= 35'(prod[4]) - 35'(prod[5]);
        n_val[1] <= 35'(prod[6]) - 35'(prod[7]);
      end
      S_CHK: begin
        for (int k = 0; k < 3; k++) u_val[k] <= u_next[k];
        if (d_val[34] || d_val == '0) begin
          res_status <= STAT_CULLED;
          res_idx    <= cur.idx[15:0];
        end else if (!cur.on) begin
          res_status <= STAT_OUTSIDE;
          res_idx    <= '0;
        end else begin
          res_status <= STAT_OUTSIDE;
          res_idx    <= cur.idx[15:0];
        end
      end
      S_TMUL: begin
        for (int k = 0; k < 3; k++)
          t_val[k] <= {32'b0, u_val[k]} * {31'b0, wprod[k]};
      end
      S_TSUM: t_sum <= 64'(t_val[0]) + 64'(t_val[1]) + 64'(t_val[2]);
      S_SHIFT: begin
        for (int k = 0; k < 3; k++)
          tn[k] <= 47'(t_val[k] >> s2);
      end
      S_ZMUL: begin
        t_tot <= 48'(tn[0]) + 48'(tn[1]) + 48'(tn[2]);
        for (int k = 0; k < 3; k++) begin
          zlo[k] <= {24'b0, vtx_z[k]} * {16'b0, tn[k][23:0]};
          zhi[k] <= {23'b0, vtx_z[k]} * {16'b0, tn[k][46:24]};
        end
      end
      S_ZADD: begin
        for (int k = 0; k < 3; k++)
          zp[k] <= {zhi[k], 24'b0} + 63'(zlo[k]);
      end
      S_ZSUM: dnum <= 64'(zp[0]) + 64'(zp[1]) + 64'(zp[2]) + 64'(t_tot >> 1);
      S_DIVWAIT: begin
        if (div_done) begin
          case (div_sel)
            2'd0:    wq[0] <= div_quo;
            2'd1:    wq[1] <= div_quo;
            2'd2:    wq[2] <= div_quo;
            default: dep_q <= div_quo;
          endcase
        end
      end
      S_CMP: begin
        res_status <= fail ? STAT_DEPTH_FAIL : STAT_WRITTEN;
        res_idx    <= cur.idx[15:0];
        res_dep    <= dep_c;
        res_w[0]   <= wq[0];
        res_w[1]   <= wq[1];
        res_w[2]   <= wq[2];
      end
      default: ;
    endcase
    if (emit_ok) begin
      status      <= res_status;
      frame_index <= res_idx;
      frag_depth  <= res_dep;
      weight_a    <= res_w[0];
      weight_b    <= res_w[1];
      weight_c    <= res_w[2];
    end
  end

  `TPDT_ASSERT_IMPLIES(a_done_in_wait, div_done, state == S_DIVWAIT, "divider result outside wait state")
  `TPDT_ASSERT_IMPLIES(a_no_pop_clear, clearing, !q_pop, "request popped during clearing pass")

endmodule

`default_nettype wire

// ===== hdl/triangle_pixel_depth_test_top.sv =====
// Triangle pixel depth test block: vertex loads, pixel tests, depth clears.
// Input channel in_valid/in_stall carries one request (mode, slot, vertex, pixel);
// output channel out_valid/out_stall carries one result per request, in order.
// Screen width/height are written on cfg_we with cfg_index 0/1; the user must
// write them only while idle, as the block itself does not enforce it.
// After reset the depth store is swept to the far value, one entry per cycle,
// over MAX_WIDTH*MAX_HEIGHT entries (65536 by default), with in_stall high.
// Loads, clears and rejected requests go from the execute state straight to the
// result; culled, off-screen and uncovered pixel tests leave after the edge check.
// A covered pixel test runs the edge, weight and depth arithmetic, then
// four 17-bit quotients on one shared restoring divider at one bit per cycle, then
// the compare. One pixel test is in work at a time; the next waits for its result.
// A four-entry queue lets requests be accepted while the back end is busy.
// While out_valid and out_stall are both high the result register holds and the
// back end waits; the queue keeps taking requests until it fills.
// depends on tpdt_pkg, tpdt_front, tpdt_fifo, tpdt_back
`default_nettype none

module triangle_pixel_depth_test_top
  import tpdt_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [1:0]         vertex_slot,
  input  logic signed [15:0] vert_x,
  input  logic signed [15:0] vert_y,
  input  logic [15:0]        vert_z,
  input  logic [15:0]        vert_w,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [15:0]        frame_index,
  output logic [15:0]        frag_depth,
  output logic [16:0]        weight_a,
  output logic [16:0]        weight_b,
  output logic [16:0]        weight_c
);

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  logic   clearing;
  entry_t push_entry;
  entry_t pop_entry;

  tpdt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .vertex_slot (vertex_slot),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_z      (vert_z),
    .vert_w      (vert_w),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .q_full      (q_full),
    .clearing    (clearing),
    .push        (push),
    .entry       (push_entry)
  );

  tpdt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rdata (pop_entry)
  );

  tpdt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_entry     (pop_entry),
    .q_pop       (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .frame_index (frame_index),
    .frag_depth  (frag_depth),
    .weight_a    (weight_a),
    .weight_b    (weight_b),
    .weight_c    (weight_c)
  );

endmodule

`default_nettype wire
